// ===== design/pfr_pkg.sv =====
// pfr_pkg: shared constants and types for the polynomial fold/reduce block
// depends on nothing; used by pfr_reduce, poly_fold_reduce_mod_q and tb

package pfr_pkg;

    // default polynomial length P
    localparam int POLY_DEGREE_DEF = 761;

    // field widths
    localparam int COEF_IN_W  = 16;
    localparam int COEF_OUT_W = 14;
    localparam int COEF_IDX_W = 10;
    localparam int SUM_W      = 18;

    // modulus and Barrett constants
    localparam logic signed [13:0] MOD_Q      = 14'sd4591;
    localparam logic signed [8:0]  BARRETT_M1 = 9'sd228;
    localparam int                 BARRETT_S1 = 20;
    localparam logic signed [16:0] BARRETT_M2 = 17'sd58470;
    localparam logic signed [35:0] BARRETT_R2 = 36'sd134217728;
    localparam int                 BARRETT_S2 = 28;

    // sideband that follows a sum through the reduction pipe
    typedef struct packed {
        logic [COEF_IDX_W-1:0] idx;
        logic                  last;
    } t_tag;

endpackage

// ===== design/pfr_ram.sv =====
// pfr_ram: generic single-port-write, single-port-read RAM, registered read
// no dependencies

module pfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 761
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pfr_reduce.sv =====
// pfr_reduce: five-stage pipe reducing an 18-bit sum modulo 4591 (two Barrett steps)
// depends on pfr_pkg; the last stage is the block's output register

module pfr_reduce (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic signed [pfr_pkg::SUM_W-1:0]   i_a,
    input  pfr_pkg::t_tag                      i_tag,
    output logic                               o_vld,
    output logic signed [pfr_pkg::COEF_OUT_W-1:0] o_coeff,
    output pfr_pkg::t_tag                      o_tag
);
    import pfr_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_vld;
    t_tag            r_tag [NSTG];

    logic signed [SUM_W-1:0]      r_a;
    logic signed [26:0]           r_p1;
    logic signed [SUM_W-1:0]      r_a_d;
    logic signed [SUM_W-1:0]      r_a1;
    logic signed [35:0]           r_p2;
    logic signed [SUM_W-1:0]      r_a1_d;
    logic signed [COEF_OUT_W-1:0] r_out;

    logic signed [6:0]  w_q1;
    logic signed [21:0] w_a1;
    logic signed [7:0]  w_q2;
    logic signed [21:0] w_a2;

    // quotient estimates and corrections
    assign w_q1 = r_p1[26:BARRETT_S1];
    assign w_a1 = 22'(r_a_d) - 22'(MOD_Q) * 22'(w_q1);
    assign w_q2 = r_p2[35:BARRETT_S2];
    assign w_a2 = 22'(r_a1_d) - 22'(MOD_Q) * 22'(w_q2);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};
        end
    end

    // datapath and sideband
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= i_a;
            r_p1     <= 27'(r_a) * 27'(BARRETT_M1);
            r_a_d    <= r_a;
            r_a1     <= w_a1[SUM_W-1:0];
            r_p2     <= 36'(r_a1) * 36'(BARRETT_M2) + BARRETT_R2;
            r_a1_d   <= r_a1;
            r_out    <= w_a2[COEF_OUT_W-1:0];
            r_tag[0] <= i_tag;
            for (int s = 1; s < NSTG; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    assign o_vld   = r_vld[NSTG-1];
    assign o_coeff = r_out;
    assign o_tag   = r_tag[NSTG-1];

endmodule

// ===== design/poly_fold_reduce_mod_q.sv =====
// poly_fold_reduce_mod_q: top level, folds a 2P-1 term product mod x^P - x - 1
// depends on pfr_pkg, pfr_ram, pfr_reduce
//
// Usage:
//   Input channel (i_valid / o_ready, i_coeff_in) takes the 2P-1 signed
//   coefficients of a product in index order, one beat per cycle. The first
//   P beats are stored in the coefficient RAM and give no output. Each later
//   beat c(P+k) gives output k = c(k) + c(P+k) (+ c(P+k-1) if k > 0); the
//   previous high coefficient is held in a register instead of being written
//   back. The final beat c(2P-2) gives outputs P-2 and P-1 (o_last = 1);
//   o_ready stays low while the second of them enters the pipe.
//   Output channel (o_valid / i_ready) carries o_coeff_out (reduced mod 4591,
//   not canonical), o_coeff_index and o_last.
//   Pipe: a result passes the RAM read, the sum register and two Barrett
//   steps of two stages each after the input beat that completes it.
//   Throughput: one input beat per cycle while not stalled; after the final
//   beat the input waits while its second result enters the pipe.
//   Stall: the whole pipe, RAM read included, holds while o_valid is high
//   and i_ready is low; o_ready is then low.
//   Reset: clears the input position and all valid bits; RAM contents are
//   left as they are and are always written before being read.

module poly_fold_reduce_mod_q #(
    parameter int POLY_DEGREE = pfr_pkg::POLY_DEGREE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [pfr_pkg::COEF_IN_W-1:0]  i_coeff_in,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [pfr_pkg::COEF_OUT_W-1:0] o_coeff_out,
    output logic [pfr_pkg::COEF_IDX_W-1:0]        o_coeff_index,
    output logic                                  o_last
);
    import pfr_pkg::*;

    localparam int AW = $clog2(POLY_DEGREE);
    localparam int PW = $clog2(2 * POLY_DEGREE - 1);

    logic [PW-1:0]                r_pos;
    logic                         r_second;
    logic signed [COEF_IN_W-1:0]  r_prev_c;
    logic                         r_s1_vld;
    logic signed [COEF_IN_W:0]    r_s1_add;
    t_tag                         r_s1_tag;

    logic                         w_adv;
    logic                         w_acc;
    logic                         w_phase_b;
    logic [PW-1:0]                w_koff;
    logic [AW-1:0]                w_k;
    logic                         w_final;
    logic                         w_re;
    logic [AW-1:0]                w_raddr;
    logic [COEF_IN_W-1:0]         w_rdata;
    logic signed [SUM_W-1:0]      w_sum;
    logic                         w_red_vld;
    t_tag                         w_red_tag;

    // handshake and position decode
    assign w_adv     = !o_valid || i_ready;
    assign o_ready   = w_adv && !r_second;
    assign w_acc     = i_valid && o_ready;
    assign w_phase_b = r_pos >= PW'(POLY_DEGREE);
    assign w_koff    = r_pos - PW'(POLY_DEGREE);
    assign w_k       = w_koff[AW-1:0];
    assign w_final   = w_phase_b && (w_k == AW'(POLY_DEGREE - 2));

    // coefficient RAM: low half written, then each address read once
    assign w_re    = w_adv && ((w_acc && w_phase_b) || r_second);
    assign w_raddr = r_second ? AW'(POLY_DEGREE - 1) : w_k;

    pfr_ram #(
        .WIDTH (COEF_IN_W),
        .DEPTH (POLY_DEGREE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc && !w_phase_b),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (i_coeff_in),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // input position, pending second result, previous high coefficient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_second <= 1'b0;
        end else begin
            if (w_acc) begin
                r_pos <= w_final ? '0 : r_pos + PW'(1);
            end
            if (w_acc && w_final) begin
                r_second <= 1'b1;
            end else if (w_adv) begin
                r_second <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_prev_c <= i_coeff_in;
        end
    end

    // stage 1: addend alongside the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= (w_acc && w_phase_b) || r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_second) begin
                r_s1_add      <= (COEF_IN_W+1)'(r_prev_c);
                r_s1_tag.idx  <= COEF_IDX_W'(POLY_DEGREE - 1);
                r_s1_tag.last <= 1'b1;
            end else begin
                r_s1_add      <= (COEF_IN_W+1)'(i_coeff_in)
                               + ((w_k == '0) ? '0 : (COEF_IN_W+1)'(r_prev_c));
                r_s1_tag.idx  <= COEF_IDX_W'(w_k);
                r_s1_tag.last <= 1'b0;
            end
        end
    end

    // folded sum: stored low coefficient plus addend
    assign w_sum = SUM_W'($signed(w_rdata)) + SUM_W'(r_s1_add);

    pfr_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_s1_vld),
        .i_a     (w_sum),
        .i_tag   (r_s1_tag),
        .o_vld   (w_red_vld),
        .o_coeff (o_coeff_out),
        .o_tag   (w_red_tag)
    );

    assign o_valid       = w_red_vld;
    assign o_coeff_index = w_red_tag.idx;
    assign o_last        = w_red_tag.last;

    // checks
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_coeff_index == COEF_IDX_W'(POLY_DEGREE - 1))
        else $error("last beat with wrong index");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_coeff_out) >= -14'sd4591) && ($signed(o_coeff_out) <= 14'sd4591))
        else $error("reduced coefficient out of range");

    a_final_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_final |=> r_second && !o_ready && r_pos == '0)
        else $error("final beat did not schedule second result");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(2 * POLY_DEGREE - 2))
        else $error("input position past end of polynomial");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for poly_fold_reduce_mod_q, a directed start of a product that random
// coefficients complete; depends on pfr_pkg and poly_fold_reduce_mod_q; every accepted result
// is checked against a local fold and mod-4591 reduction predictor

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POLY         = pfr_pkg::POLY_DEGREE_DEF;
    localparam int IN_W         = pfr_pkg::COEF_IN_W;
    localparam int OUT_W        = pfr_pkg::COEF_OUT_W;
    localparam int IDX_W        = pfr_pkg::COEF_IDX_W;
    localparam int SUM_W        = pfr_pkg::SUM_W;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT_A    = 100;
    localparam int HOLD_AT_B    = 500;
    localparam int DRAIN_CYCLES = 20;

    // reduction constants
    localparam longint Q_MOD  = 4591;
    localparam longint B1_MUL = 228;
    localparam int     B1_SH  = 20;
    localparam longint B2_MUL = 58470;
    localparam longint B2_RND = 134217728;
    localparam int     B2_SH  = 28;

    typedef struct {
        logic signed [pfr_pkg::COEF_OUT_W-1:0] coeff;
        logic [pfr_pkg::COEF_IDX_W-1:0]        index;
        logic                                  last_flag;
    } t_folded_coeff;

    // one row is a run of equal input coefficients; fixed rows carry a known result value
    typedef struct {
        int run;
        int value;
        bit fixed;
        int fixed_out;
    } t_coeff_run;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_valid = 1'b0;
    logic                                  o_ready;
    logic signed [pfr_pkg::COEF_IN_W-1:0]  i_coeff_in = '0;
    logic                                  o_valid;
    logic                                  i_ready = 1'b0;
    logic signed [pfr_pkg::COEF_OUT_W-1:0] o_coeff_out;
    logic [pfr_pkg::COEF_IDX_W-1:0]        o_coeff_index;
    logic                                  o_last;

    // predictor state
    logic signed [pfr_pkg::SUM_W-1:0] fold_sums [POLY];
    int                               fold_pos = 0;
    t_folded_coeff                    expected_coeffs [$];

    int items_sent   = 0;
    int results_seen = 0;
    int failures     = 0;

    // directed start of a product: extremes in both halves, max and min three-term
    // sums, +-4591, and a zero stretch whose folded results must all be zero
    t_coeff_run directed_runs [18] = '{
        '{1,   32767, 1'b0, 0},
        '{1,  -32768, 1'b0, 0},
        '{1,    4591, 1'b0, 0},
        '{1,   -4591, 1'b0, 0},
        '{1,   32767, 1'b0, 0},
        '{1,  -32768, 1'b0, 0},
        '{1,  -32768, 1'b0, 0},
        '{753,     0, 1'b0, 0},
        '{1,   32767, 1'b0, 0},
        '{1,   32767, 1'b0, 0},
        '{1,  -32768, 1'b0, 0},
        '{1,   32767, 1'b0, 0},
        '{1,   32767, 1'b0, 0},
        '{1,   32767, 1'b0, 0},
        '{1,  -32768, 1'b0, 0},
        '{1,  -32768, 1'b0, 0},
        '{1,       0, 1'b0, 0},
        '{40,      0, 1'b1, 0}
    };

    poly_fold_reduce_mod_q #(
        .POLY_DEGREE(POLY)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_coeff_in   (i_coeff_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_coeff_out  (o_coeff_out),
        .o_coeff_index(o_coeff_index),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    // mostly back to back, sometimes a short gap, rarely a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // reduce a folded sum mod q with two floor-shift Barrett steps and queue it
    task automatic push_folded(input longint sum, input int idx, input bit fixed,
                               input int fixed_out);
        t_folded_coeff e;
        longint        a;
        a = sum;
        a = a - Q_MOD * ((B1_MUL * a) >>> B1_SH);
        a = a - Q_MOD * ((B2_MUL * a + B2_RND) >>> B2_SH);
        e.coeff     = a[pfr_pkg::COEF_OUT_W-1:0];
        if (fixed)
            e.coeff = OUT_W'(fixed_out);
        e.index     = IDX_W'(idx);
        e.last_flag = (idx == POLY - 1);
        expected_coeffs.push_back(e);
    endtask

    // fold one accepted coefficient into the running sums
    task automatic fold_coefficient(input logic signed [pfr_pkg::COEF_IN_W-1:0] c,
                                    input bit fixed, input int fixed_out);
        int k;
        if (fold_pos < POLY) begin
            fold_sums[fold_pos] = SUM_W'(c);
            fold_pos++;
        end else begin
            k = fold_pos - POLY;
            push_folded(longint'(fold_sums[k]) + longint'(c), k, fixed, fixed_out);
            fold_sums[k + 1] = fold_sums[k + 1] + SUM_W'(c);
            if (k == POLY - 2) begin
                push_folded(longint'(fold_sums[k + 1]), k + 1, 1'b0, 0);
                fold_pos = 0;
            end else begin
                fold_pos++;
            end
        end
    endtask

    // offer one beat after a random gap and wait until it is taken
    task automatic send_coeff(input logic signed [pfr_pkg::COEF_IN_W-1:0] value,
                              input bit fixed, input int fixed_out);
        int gap;
        gap = ((items_sent / 250) % 4 == 2) ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid    <= 1'b0;
            i_coeff_in <= IN_W'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_coeff_in <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        fold_coefficient(value, fixed, fixed_out);
        items_sent++;
    endtask

    // stop offering until every expected result is out
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_coeffs.size() != 0) @(posedge i_clk);
    endtask

    // main stimulus
    initial begin
        int                                   sel;
        logic signed [pfr_pkg::COEF_IN_W-1:0] c;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_runs[r]) begin
            repeat (directed_runs[r].run)
                send_coeff(directed_runs[r].value, directed_runs[r].fixed,
                           directed_runs[r].fixed_out);
        end
        drain_results();

        // random coefficients up to the end of the product: extremes, small values,
        // multiples of q, full range
        do begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: c = 16'sh7FFF;
                1: c = 16'sh8000;
                2, 3: c = IN_W'(int'($urandom_range(0, 40)) - 20);
                4: c = IN_W'((int'($urandom_range(0, 14)) - 7) * 4591);
                default: c = IN_W'($urandom);
            endcase
            send_coeff(c, 1'b0, 0);
        end while (fold_pos != 0);
        drain_results();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && expected_coeffs.size() == 0) begin
            $display("poly_fold_reduce_mod_q: match");
        end else begin
            $display("poly_fold_reduce_mod_q: mismatch");
        end
        $finish;
    end

    // output side backpressure: random stalls, quiet stretches, two long holds
    initial begin
        int run_left;
        int stall_left;
        int hold_left;
        int holds_done;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (holds_done < 2 &&
                         results_seen >= (holds_done == 0 ? HOLD_AT_A : HOLD_AT_B)) begin
                i_ready   <= 1'b0;
                hold_left = LONG_HOLD - 1;
                holds_done++;
            end else if ((results_seen / 200) % 3 == 1) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left   = $urandom_range(0, 12);
                    stall_left = pick_gap();
                end
            end
        end
    end

    // compare each output beat with the oldest expected result
    always @(posedge i_clk) begin : result_check
        t_folded_coeff e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_coeffs.size() == 0) begin
                $error("unexpected result beat, index %0d", o_coeff_index);
                failures++;
            end else begin
                e = expected_coeffs.pop_front();
                if (o_coeff_out !== e.coeff) begin
                    $error("coeff_out: expected %0d, got %0d", e.coeff, o_coeff_out);
                    failures++;
                end
                if (o_coeff_index !== e.index) begin
                    $error("coeff_index: expected %0d, got %0d", e.index, o_coeff_index);
                    failures++;
                end
                if (o_last !== e.last_flag) begin
                    $error("last: expected %0d, got %0d", e.last_flag, o_last);
                    failures++;
                end
            end
        end
    end

    // hard limit on run time
    initial begin
        #20_000_000;
        $display("poly_fold_reduce_mod_q: mismatch");
        $finish;
    end

endmodule

// ===== poly_fold_reduce_mod_q.f =====
design/pfr_pkg.sv
design/pfr_ram.sv
design/pfr_reduce.sv
design/poly_fold_reduce_mod_q.sv
tb/tb.sv
